@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the voice allocator rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under clock and active-low reset
`define SVA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define SVA_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVA_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sva_pkg.sv @@
// types, constants and helpers of the voice allocator with envelopes
// no dependencies; imported by the controller, the datapath and the top level
package sva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SLOT_W     = 3;
    localparam int CNT_W      = 4;
    localparam int LEVEL_W    = 25;
    localparam int SRC_W      = 8;
    localparam int PEAK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 2 * LEVEL_W;

    localparam logic [LEVEL_W-1:0] ONE_Q24      = 25'h100_0000;
    localparam logic [LEVEL_W-1:0] START_LEVEL  = 25'd1678;
    localparam logic [PEAK_W-1:0]  PEAK_MAX     = 16'd32768;
    localparam logic [LEVEL_W-1:0] RATE_RESET   = 25'd1087;
    localparam logic [LEVEL_W-1:0] COEF_RESET   = 25'd380;
    localparam logic [LEVEL_W-1:0] THR_RESET    = 25'd168;
    localparam logic [PROD_W-1:0]  RND_HALF     = PROD_W'(64'd1 << 23);
    localparam logic [PROD_W-1:0]  RND_UP       = PROD_W'((64'd1 << 24) - 64'd1);
    localparam logic [IDX_W-1:0]   IDX_LAST     = IDX_W'(NUM_VOICES - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THR     = 2'd2;

    typedef enum logic [1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_ALL_OFF  = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        OUT_NOTE_ON  = 2'd0,
        OUT_NOTE_OFF = 2'd1,
        OUT_ALL_OFF  = 2'd2,
        OUT_TICK     = 2'd3
    } t_out_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_STEP_MUL,
        S_NOTE_ON,
        S_NOTE_OFF,
        S_ALL_OFF,
        S_ADV_MUL,
        S_ADV_UPD,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic             load_in;
        logic             scan_clr;
        logic             scan_en;
        logic             use_sel;
        logic             mul_attack;
        logic             mul_release;
        logic             adv_en;
        logic             alloc;
        logic             release_one;
        logic             all_off;
        logic             out_load;
        t_out_kind        out_kind;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic [LEVEL_W-1:0] sat_one(input logic [LEVEL_W-1:0] v);
        return (v > ONE_Q24) ? ONE_Q24 : v;
    endfunction

endpackage

@@ hw/rtl/sva_ctrl.sv @@
// sequencer of the voice allocator: scans, envelope advance and result emission
// depends on sva_pkg and assert_macros.svh
`include "assert_macros.svh"

module sva_ctrl import sva_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_action          r_action, n_action;
    logic             idx_last;

    assign idx_last = (r_idx == IDX_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_action <= ACT_NOTE_ON;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_action <= n_action;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_action   = r_action;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in  = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_idx          = '0;
                    n_action       = t_action'(i_action);
                    case (t_action'(i_action))
                        ACT_NOTE_ON:  n_state = S_SCAN;
                        ACT_NOTE_OFF: n_state = S_SCAN;
                        ACT_ALL_OFF:  n_state = S_ALL_OFF;
                        ACT_TICK:     n_state = S_ADV_MUL;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (idx_last) begin
                    n_state = (r_action == ACT_NOTE_ON) ? S_STEP_MUL : S_NOTE_OFF;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_STEP_MUL: begin
                o_cmd.mul_attack = 1'b1;
                n_state          = S_NOTE_ON;
            end
            S_NOTE_ON: begin
                o_cmd.use_sel = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.alloc    = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_NOTE_ON;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_NOTE_OFF: begin
                o_cmd.use_sel = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.release_one = 1'b1;
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_kind    = OUT_NOTE_OFF;
                    o_cmd.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_ALL_OFF: begin
                if (i_stat.out_free) begin
                    o_cmd.all_off  = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_ALL_OFF;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ADV_MUL: begin
                o_cmd.mul_release = 1'b1;
                n_state           = S_ADV_UPD;
            end
            S_ADV_UPD: begin
                o_cmd.adv_en = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = S_REPORT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ADV_MUL;
                end
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_TICK;
                    o_cmd.last     = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `SVA_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready stayed high after accept")
    `SVA_IMPLIES(a_load_only_when_free, i_clk, i_rst_n, o_cmd.out_load, i_stat.out_free, "result loaded over a waiting result")
    `SVA_IMPLIES(a_advance_only_on_tick, i_clk, i_rst_n, o_cmd.adv_en, r_action == ACT_TICK, "envelope advanced outside a tick")

endmodule

@@ hw/rtl/sva_datapath.sv @@
// voice table, envelope arithmetic, configuration registers and result register
// depends on sva_pkg and assert_macros.svh
`include "assert_macros.svh"

module sva_datapath import sva_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    input  logic [SRC_W-1:0]     i_source_id,
    input  logic [PEAK_W-1:0]    i_peak_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [LEVEL_W-1:0]   o_level,
    output logic                 o_voice_active,
    output logic                 o_retriggered,
    output logic                 o_stolen,
    output logic                 o_found,
    output logic [CNT_W-1:0]     o_active_count,
    output logic                 o_last
);

    // configuration
    logic [LEVEL_W-1:0] r_attack_rate, r_release_coef, r_idle_thr;

    // voice table
    logic [NUM_VOICES-1:0] r_used;
    t_phase                r_phase [NUM_VOICES];
    logic [LEVEL_W-1:0]    r_level [NUM_VOICES];
    logic [SRC_W-1:0]      r_src   [NUM_VOICES];
    logic [LEVEL_W-1:0]    r_peak  [NUM_VOICES];
    logic [LEVEL_W-1:0]    r_step  [NUM_VOICES];
    logic [CNT_W-1:0]      r_count;

    // latched item and scan results
    logic [SRC_W-1:0]   r_src_in;
    logic [LEVEL_W-1:0] r_peak_in;
    logic               r_match_hit, r_free_hit;
    logic [IDX_W-1:0]   r_match_idx, r_free_idx, r_min_idx;
    logic [LEVEL_W-1:0] r_min_level;
    logic [PROD_W-1:0]  r_prod;

    // result register
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_active, r_out_retrig, r_out_stolen, r_out_found, r_out_last;
    logic [CNT_W-1:0]   r_out_count;

    logic [IDX_W-1:0]   sel_idx, rd_idx;
    logic [PEAK_W-1:0]  peak_sat;
    logic [LEVEL_W-1:0] mul_a, mul_b, rd_level;
    logic [PROD_W-1:0]  step_rnd, rel_rnd;
    logic [LEVEL_W-1:0] step_new;
    logic [LEVEL_W:0]   att_sum, rel_dec;
    logic [LEVEL_W-1:0] rel_new;
    logic               att_done, rel_free, grows;
    logic [SLOT_W-1:0]  n_out_slot;
    logic [LEVEL_W-1:0] n_out_level;
    logic               n_out_active, n_out_retrig, n_out_stolen, n_out_found;
    logic [CNT_W-1:0]   n_out_count;

    assign sel_idx  = r_match_hit ? r_match_idx : (r_free_hit ? r_free_idx : r_min_idx);
    assign rd_idx   = i_cmd.use_sel ? sel_idx : i_cmd.idx;
    assign rd_level = r_level[rd_idx];
    assign peak_sat = (i_peak_level > PEAK_MAX) ? PEAK_MAX : i_peak_level;
    assign grows    = !r_match_hit && r_free_hit;

    // one shared multiplier: attack step at note on, release decrement on tick
    assign mul_a = i_cmd.mul_attack ? r_peak_in : rd_level;
    assign mul_b = i_cmd.mul_attack ? sat_one(r_attack_rate) : sat_one(r_release_coef);

    assign step_rnd = r_prod + RND_HALF;
    assign step_new = (step_rnd[PROD_W-1:24] == '0) ? LEVEL_W'(1)
                                                    : LEVEL_W'(step_rnd[PROD_W-1:24]);
    assign rel_rnd  = r_prod + RND_UP;
    assign rel_dec  = (LEVEL_W + 1)'(rel_rnd[PROD_W-1:24]);
    assign rel_new  = (rel_dec >= {1'b0, rd_level}) ? '0 : (rd_level - rel_dec[LEVEL_W-1:0]);
    assign rel_free = (rel_new <= r_idle_thr);
    assign att_sum  = {1'b0, rd_level} + {1'b0, r_step[rd_idx]};
    assign att_done = (att_sum >= {1'b0, r_peak[rd_idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_rate  <= RATE_RESET;
            r_release_coef <= COEF_RESET;
            r_idle_thr     <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ATTACK_RATE:  r_attack_rate  <= i_cfg_data;
                CFG_RELEASE_COEF: r_release_coef <= i_cfg_data;
                CFG_IDLE_THR:     r_idle_thr     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_phase[i] <= PH_IDLE;
                r_level[i] <= '0;
            end
        end else begin
            if (i_cmd.alloc) begin
                r_used[rd_idx]  <= 1'b1;
                r_phase[rd_idx] <= PH_ATTACK;
                if (!r_match_hit) begin
                    r_level[rd_idx] <= START_LEVEL;
                end
                if (grows) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.release_one && r_match_hit && r_phase[rd_idx] != PH_IDLE) begin
                r_phase[rd_idx] <= PH_RELEASE;
            end
            if (i_cmd.all_off) begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (r_used[i] && r_phase[i] != PH_IDLE) begin
                        r_phase[i] <= PH_RELEASE;
                    end
                end
            end
            if (i_cmd.adv_en && r_used[rd_idx]) begin
                case (r_phase[rd_idx])
                    PH_ATTACK: begin
                        if (att_done) begin
                            r_level[rd_idx] <= r_peak[rd_idx];
                            r_phase[rd_idx] <= PH_HOLD;
                        end else begin
                            r_level[rd_idx] <= att_sum[LEVEL_W-1:0];
                        end
                    end
                    PH_RELEASE: begin
                        if (rel_free) begin
                            r_level[rd_idx] <= '0;
                            r_phase[rd_idx] <= PH_IDLE;
                            r_used[rd_idx]  <= 1'b0;
                            r_count         <= r_count - 1'b1;
                        end else begin
                            r_level[rd_idx] <= rel_new;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // per-voice payload, written only when a voice is taken; also the latched item and the product
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_src[rd_idx]  <= r_src_in;
            r_peak[rd_idx] <= r_peak_in;
            r_step[rd_idx] <= step_new;
        end
        if (i_cmd.load_in) begin
            r_src_in  <= i_source_id;
            r_peak_in <= LEVEL_W'(peak_sat) << 9;
        end
        if (i_cmd.mul_attack || i_cmd.mul_release) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // scan: first match, first free slot, quietest used voice before it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_min_level <= '1;
            r_min_idx   <= '0;
        end else if (i_cmd.scan_en) begin
            if (r_used[rd_idx] && r_src[rd_idx] == r_src_in && !r_match_hit) begin
                r_match_hit <= 1'b1;
                r_match_idx <= rd_idx;
            end
            if (!r_free_hit) begin
                if (!r_used[rd_idx]) begin
                    r_free_hit <= 1'b1;
                    r_free_idx <= rd_idx;
                end else if (rd_level < r_min_level) begin
                    r_min_level <= rd_level;
                    r_min_idx   <= rd_idx;
                end
            end
        end
    end

    always_comb begin
        n_out_slot   = '0;
        n_out_level  = '0;
        n_out_active = 1'b0;
        n_out_retrig = 1'b0;
        n_out_stolen = 1'b0;
        n_out_found  = 1'b0;
        n_out_count  = r_count;
        case (i_cmd.out_kind)
            OUT_NOTE_ON: begin
                n_out_slot   = SLOT_W'(rd_idx);
                n_out_level  = r_match_hit ? rd_level : START_LEVEL;
                n_out_active = 1'b1;
                n_out_retrig = r_match_hit;
                n_out_stolen = !r_match_hit && !r_free_hit;
                n_out_count  = grows ? (r_count + 1'b1) : r_count;
            end
            OUT_NOTE_OFF: begin
                if (r_match_hit) begin
                    n_out_slot   = SLOT_W'(rd_idx);
                    n_out_level  = rd_level;
                    n_out_active = r_used[rd_idx];
                    n_out_found  = 1'b1;
                end
            end
            OUT_ALL_OFF: ;
            OUT_TICK: begin
                n_out_slot   = SLOT_W'(rd_idx);
                n_out_level  = rd_level;
                n_out_active = r_used[rd_idx];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_slot   <= n_out_slot;
            r_out_level  <= n_out_level;
            r_out_active <= n_out_active;
            r_out_retrig <= n_out_retrig;
            r_out_stolen <= n_out_stolen;
            r_out_found  <= n_out_found;
            r_out_count  <= n_out_count;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_slot          = r_out_slot;
    assign o_level         = r_out_level;
    assign o_voice_active  = r_out_active;
    assign o_retriggered   = r_out_retrig;
    assign o_stolen        = r_out_stolen;
    assign o_found         = r_out_found;
    assign o_active_count  = r_out_count;
    assign o_last          = r_out_last;

    `SVA_ASSERT(a_count_tracks_used, i_clk, i_rst_n, r_count == CNT_W'($countones(r_used)), "active count out of step with used voices")
    `SVA_IMPLIES(a_alloc_has_room, i_clk, i_rst_n, i_cmd.alloc && grows, r_count < CNT_W'(NUM_VOICES), "free slot taken with table full")
    `SVA_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid, "waiting result dropped")

endmodule

@@ hw/rtl/synth_voice_allocator_envelope.sv @@
// Voice allocator with per-voice envelopes, eight slots, Q1.24 levels.
// Input channel (i_in_valid/o_in_ready) takes one item: note on, note off,
// all off or one sample tick. Results leave on o_out_valid/i_out_ready, one
// per note on, note off and all off, and one per slot in slot order for a
// tick; o_last marks the final result of an item.
// The configuration channel (i_cfg_valid/o_cfg_ready) is always ready and
// writes attack rate (0), release fraction (1) and idle threshold (2).
// One item at a time: the controller walks the slots over a single read
// port of the voice table, one per cycle in a scan, and the shared 25x25
// multiplier has a registered product.
//   note on:  scan of all slots, multiply, then the result
//   note off: scan of all slots, then the result; all off: the result only
//   tick:     envelope update of each slot (multiply, then update), then
//             one result per slot
// A stalled receiver holds the result register; the block waits and takes no
// new item until all results of the current one are loaded.
// Synchronous active-low reset empties the table and loads the register
// defaults; no clearing pass is needed.
module synth_voice_allocator_envelope import sva_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [SRC_W-1:0]     i_source_id,
    input  logic [PEAK_W-1:0]    i_peak_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [LEVEL_W-1:0]   o_level,
    output logic                 o_voice_active,
    output logic                 o_retriggered,
    output logic                 o_stolen,
    output logic                 o_found,
    output logic [CNT_W-1:0]     o_active_count,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    sva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sva_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_source_id    (i_source_id),
        .i_peak_level   (i_peak_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_slot         (o_slot),
        .o_level        (o_level),
        .o_voice_active (o_voice_active),
        .o_retriggered  (o_retriggered),
        .o_stolen       (o_stolen),
        .o_found        (o_found),
        .o_active_count (o_active_count),
        .o_last         (o_last)
    );

endmodule
